[hdl/lzd_pkg.sv]
// Shared types and constants for the LZ literal/copy decompressor.
package lzd_pkg;

  localparam int WINDOW_DEPTH = 1024;
  localparam int ADDR_BITS    = $clog2(WINDOW_DEPTH);
  localparam int OFFSET_BITS  = ADDR_BITS + 1;
  localparam int LENGTH_BITS  = 24;
  localparam int COUNT_BITS   = 6;
  localparam int LIT_BITS     = 8;

  localparam logic [COUNT_BITS-1:0] COPY_MIN_LEN = COUNT_BITS'(3);
  localparam logic                  MODE_START   = 1'b0;

  typedef struct packed {
    logic        mode;
    logic [7:0]  code_byte;
    logic [23:0] total_length;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_stream;
    logic       bad_reference;
  } out_t;

  typedef enum logic [2:0] {
    S_CODE,
    S_LITERAL,
    S_OFFSET,
    S_COPY_RD,
    S_COPY_WR
  } state_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic lit_load;
    logic copy_hdr;
    logic emit_lit;
    logic copy_load;
    logic rd;
    logic emit_copy;
    logic emit_bad;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_copy;
    logic slot_free;
    logic lit_last;
    logic copy_done;
    logic ref_bad;
  } status_t;

endpackage

[hdl/lzd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/lzd_ctrl.sv]
// Token parser and copy sequencer state machine.
module lzd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  lzd_pkg::status_t status,
  output lzd_pkg::cmd_t    cmd
);

  lzd_pkg::state_t state_r;
  lzd_pkg::state_t state_nxt;
  logic            take_ok;
  logic            acc;

  always_comb begin
    take_ok = ((state_r == lzd_pkg::S_CODE) || (state_r == lzd_pkg::S_LITERAL) ||
               (state_r == lzd_pkg::S_OFFSET)) && status.slot_free;
    acc = take_ok && in_valid;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lzd_pkg::S_CODE: begin
        if (acc && !status.is_start) begin
          state_nxt = status.is_copy ? lzd_pkg::S_OFFSET : lzd_pkg::S_LITERAL;
        end
      end
      lzd_pkg::S_LITERAL: begin
        if (acc && (status.is_start || status.lit_last)) begin
          state_nxt = lzd_pkg::S_CODE;
        end
      end
      lzd_pkg::S_OFFSET: begin
        if (acc) begin
          state_nxt = status.is_start ? lzd_pkg::S_CODE : lzd_pkg::S_COPY_RD;
        end
      end
      lzd_pkg::S_COPY_RD: begin
        if (status.copy_done) begin
          state_nxt = lzd_pkg::S_CODE;
        end else if (!status.ref_bad) begin
          state_nxt = lzd_pkg::S_COPY_WR;
        end
      end
      lzd_pkg::S_COPY_WR: begin
        if (status.slot_free) begin
          state_nxt = lzd_pkg::S_COPY_RD;
        end
      end
      default: state_nxt = lzd_pkg::S_CODE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.accept = take_ok;
    unique case (state_r)
      lzd_pkg::S_CODE: begin
        cmd.start    = acc && status.is_start;
        cmd.copy_hdr = acc && !status.is_start && status.is_copy;
        cmd.lit_load = acc && !status.is_start && !status.is_copy;
      end
      lzd_pkg::S_LITERAL: begin
        cmd.start    = acc && status.is_start;
        cmd.emit_lit = acc && !status.is_start;
      end
      lzd_pkg::S_OFFSET: begin
        cmd.start     = acc && status.is_start;
        cmd.copy_load = acc && !status.is_start;
      end
      lzd_pkg::S_COPY_RD: begin
        cmd.emit_bad = !status.copy_done && status.ref_bad && status.slot_free;
        cmd.rd       = !status.copy_done && !status.ref_bad;
      end
      lzd_pkg::S_COPY_WR: begin
        cmd.emit_copy = status.slot_free;
      end
      default: cmd.accept = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzd_pkg::S_CODE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/lzd_datapath.sv]
// Counters, token registers, history window and output register.
module lzd_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  lzd_pkg::in_t     in_data,
  input  logic             out_stall,
  input  lzd_pkg::cmd_t    cmd,
  output lzd_pkg::status_t status,
  output logic             out_valid,
  output lzd_pkg::out_t    out_data
);

  logic [lzd_pkg::LENGTH_BITS-1:0] expected_r, expected_nxt;
  logic [lzd_pkg::LENGTH_BITS-1:0] produced_r, produced_nxt;
  logic [lzd_pkg::LIT_BITS-1:0]    lit_left_r, lit_left_nxt;
  logic [4:0]                      copy_len_r, copy_len_nxt;
  logic [1:0]                      off_hi_r, off_hi_nxt;
  logic [lzd_pkg::OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [lzd_pkg::COUNT_BITS-1:0]  count_r, count_nxt;
  logic                            out_valid_r, out_valid_nxt;
  lzd_pkg::out_t                   out_data_r, out_data_nxt;

  logic                            can_emit;
  logic                            emit;
  logic [7:0]                      emit_byte;
  logic [7:0]                      rdata;
  logic [lzd_pkg::ADDR_BITS-1:0]   raddr;
  logic [lzd_pkg::LENGTH_BITS-1:0] produced_inc;

  assign can_emit     = produced_r < expected_r;
  assign produced_inc = produced_r + lzd_pkg::LENGTH_BITS'(1);
  assign raddr        = produced_r[lzd_pkg::ADDR_BITS-1:0] -
                        offset_r[lzd_pkg::ADDR_BITS-1:0];

  always_comb begin
    status.is_start  = (in_data.mode == lzd_pkg::MODE_START);
    status.is_copy   = in_data.code_byte[7];
    status.slot_free = !out_valid_r || !out_stall;
    status.lit_last  = (lit_left_r == lzd_pkg::LIT_BITS'(1));
    status.copy_done = (count_r == '0) || !can_emit;
    status.ref_bad   = lzd_pkg::LENGTH_BITS'(offset_r) > produced_r;
  end

  always_comb begin
    emit = (cmd.emit_lit && can_emit) || cmd.emit_bad || cmd.emit_copy;
    priority if (cmd.emit_lit) begin
      emit_byte = in_data.code_byte;
    end else if (cmd.emit_copy) begin
      emit_byte = rdata;
    end else begin
      emit_byte = 8'h00;
    end
  end

  always_comb begin
    expected_nxt  = expected_r;
    produced_nxt  = produced_r;
    lit_left_nxt  = lit_left_r;
    copy_len_nxt  = copy_len_r;
    off_hi_nxt    = off_hi_r;
    offset_nxt    = offset_r;
    count_nxt     = count_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cmd.start) begin
      expected_nxt = lzd_pkg::LENGTH_BITS'(in_data.total_length);
      produced_nxt = '0;
      lit_left_nxt = '0;
      copy_len_nxt = '0;
      off_hi_nxt   = '0;
      count_nxt    = '0;
    end
    if (cmd.lit_load) begin
      lit_left_nxt = lzd_pkg::LIT_BITS'({1'b0, in_data.code_byte[6:0]}) +
                     lzd_pkg::LIT_BITS'(1);
    end
    if (cmd.emit_lit) begin
      lit_left_nxt = lit_left_r - lzd_pkg::LIT_BITS'(1);
    end
    if (cmd.copy_hdr) begin
      copy_len_nxt = in_data.code_byte[6:2];
      off_hi_nxt   = in_data.code_byte[1:0];
    end
    if (cmd.copy_load) begin
      count_nxt    = lzd_pkg::COUNT_BITS'(copy_len_r) + lzd_pkg::COPY_MIN_LEN;
      offset_nxt   = lzd_pkg::OFFSET_BITS'({off_hi_r, in_data.code_byte}) +
                     lzd_pkg::OFFSET_BITS'(1);
      copy_len_nxt = '0;
      off_hi_nxt   = '0;
    end
    if (cmd.emit_bad || cmd.emit_copy) begin
      count_nxt = count_r - lzd_pkg::COUNT_BITS'(1);
    end
    if (emit) begin
      produced_nxt                = produced_inc;
      out_valid_nxt               = 1'b1;
      out_data_nxt.out_byte       = emit_byte;
      out_data_nxt.last_of_stream = (produced_inc == expected_r);
      out_data_nxt.bad_reference  = cmd.emit_bad;
    end
  end

  lzd_ram #(
    .WIDTH(8),
    .DEPTH(lzd_pkg::WINDOW_DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (emit),
    .waddr(produced_r[lzd_pkg::ADDR_BITS-1:0]),
    .wdata(emit_byte),
    .re   (cmd.rd),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r  <= '0;
      produced_r  <= '0;
      lit_left_r  <= '0;
      copy_len_r  <= '0;
      off_hi_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      expected_r  <= expected_nxt;
      produced_r  <= produced_nxt;
      lit_left_r  <= lit_left_nxt;
      copy_len_r  <= copy_len_nxt;
      off_hi_r    <= off_hi_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    offset_r   <= offset_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/lz_literal_copy_decompressor_unit.sv]
// Top level of the LZ literal/copy decompressor.
// Input channel (in_valid/in_stall/in_data): mode 0 starts a stream and sets
// the expected output length; mode 1 carries one compressed byte.
// Output channel (out_valid/out_stall/out_data): one decompressed byte per
// transfer, flagged on the last byte of the stream and on a copy that reaches
// before the stream start (byte then reads as zero).
// Start items and token header bytes produce no output.
// A literal byte is taken and appears on the output register in the next
// cycle. A copy token expands one output byte at a time (read of the
// 1024-byte history RAM, then write-back and output); a byte whose reference
// lies before the stream start skips the read. The input stalls while a copy runs.
// Bytes beyond the expected length are dropped. Every copy closes with a final
// pass through the read state that emits nothing.
// Reset clears the parser and counters; the history RAM is not cleared.
// A stalled output holds its transfer; any input item is only taken once the
// output register can receive a new byte.
module lz_literal_copy_decompressor_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lzd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lzd_pkg::out_t out_data
);

  lzd_pkg::cmd_t    cmd;
  lzd_pkg::status_t status;

  lzd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .status  (status),
    .cmd     (cmd)
  );

  lzd_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_stall(out_stall),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  assign in_stall = !cmd.accept;

endmodule

[tb/sv/tb_top.sv]
// Testbench for lz_literal_copy_decompressor_unit: token streams checked against a decoder model.
`timescale 1ns / 100ps

module tb_top;

  localparam logic       MODE_DATA = ~lzd_pkg::MODE_START;
  localparam logic [7:0] COPY_FLAG = 8'h80;
  localparam int         MAX_LITERAL_RUN = 128;
  localparam int         MAX_COPY_LEN = 34;
  localparam int         DRAIN_CYCLES = 120;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  lzd_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  lzd_pkg::out_t out_data;

  int unsigned items_sent = 0;
  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  // decoder model state
  logic [7:0]      hist_mem [lzd_pkg::WINDOW_DEPTH];
  lzd_pkg::state_t parse_state = lzd_pkg::S_CODE;
  logic [7:0]      literals_due = '0;
  logic [4:0]      copy_len_code = '0;
  logic [1:0]      offset_hi = '0;
  logic [23:0]     bytes_out = '0;
  logic [23:0]     stream_len = '0;
  lzd_pkg::out_t   pending_bytes [$];

  lz_literal_copy_decompressor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  function automatic void produce_byte(logic [7:0] b, logic bad);
    lzd_pkg::out_t r;
    if (bytes_out >= stream_len) return;
    hist_mem[bytes_out[lzd_pkg::ADDR_BITS-1:0]] = b;
    bytes_out = bytes_out + 24'd1;
    r.out_byte = b;
    r.last_of_stream = (bytes_out == stream_len);
    r.bad_reference = bad;
    pending_bytes.push_back(r);
  endfunction

  function automatic void decode_item(lzd_pkg::in_t it);
    logic [10:0] offset;
    logic [23:0] src;
    int unsigned count;
    if (it.mode == lzd_pkg::MODE_START) begin
      stream_len = it.total_length;
      bytes_out = '0;
      parse_state = lzd_pkg::S_CODE;
      literals_due = '0;
      copy_len_code = '0;
      offset_hi = '0;
      return;
    end
    case (parse_state)
      lzd_pkg::S_LITERAL: begin
        produce_byte(it.code_byte, 1'b0);
        literals_due = literals_due - 8'd1;
        if (literals_due == '0) parse_state = lzd_pkg::S_CODE;
      end
      lzd_pkg::S_OFFSET: begin
        offset = {1'b0, offset_hi, it.code_byte} + 11'd1;
        count = copy_len_code + lzd_pkg::COPY_MIN_LEN;
        for (int unsigned i = 0; i < count; i++) begin
          if (24'(offset) > bytes_out) begin
            produce_byte(8'h00, 1'b1);
          end else begin
            src = bytes_out - 24'(offset);
            produce_byte(hist_mem[src[lzd_pkg::ADDR_BITS-1:0]], 1'b0);
          end
        end
        parse_state = lzd_pkg::S_CODE;
        copy_len_code = '0;
        offset_hi = '0;
      end
      default: begin
        if (it.code_byte[7]) begin
          copy_len_code = it.code_byte[6:2];
          offset_hi = it.code_byte[1:0];
          parse_state = lzd_pkg::S_OFFSET;
        end else begin
          literals_due = {1'b0, it.code_byte[6:0]} + 8'd1;
          parse_state = lzd_pkg::S_LITERAL;
        end
      end
    endcase
  endfunction

  // one input transfer; the model is updated at the accepting edge
  task automatic send_item(input lzd_pkg::in_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    decode_item(item);
    items_sent++;
  endtask

  task automatic send_start(input logic [23:0] len);
    lzd_pkg::in_t it;
    it.mode = lzd_pkg::MODE_START;
    it.code_byte = 8'($urandom);
    it.total_length = len;
    send_item(it);
  endtask

  task automatic send_code(input logic [7:0] b);
    lzd_pkg::in_t it;
    it.mode = MODE_DATA;
    it.code_byte = b;
    it.total_length = 24'($urandom);
    send_item(it);
  endtask

  task automatic send_literals(input int unsigned n);
    send_code(8'(n - 1));
    repeat (n) send_code(8'($urandom));
  endtask

  task automatic send_copy(input int unsigned len, input int unsigned offset);
    logic [9:0] off_m1;
    off_m1 = 10'(offset - 1);
    send_code(COPY_FLAG | {1'b0, 5'(len - lzd_pkg::COPY_MIN_LEN), off_m1[9:8]});
    send_code(off_m1[7:0]);
  endtask

  always @(negedge clk) begin : check_output
    lzd_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected output transfer, expected none, got %h", $time, out_data);
        fail_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %h, got %h", $time, want.out_byte,
                   out_data.out_byte);
          fail_count++;
        end
        if (out_data.last_of_stream !== want.last_of_stream) begin
          $display("%0t: last_of_stream expected %b, got %b", $time, want.last_of_stream,
                   out_data.last_of_stream);
          fail_count++;
        end
        if (out_data.bad_reference !== want.bad_reference) begin
          $display("%0t: bad_reference expected %b, got %b", $time, want.bad_reference,
                   out_data.bad_reference);
          fail_count++;
        end
      end
    end
  end

  task automatic test_no_stream();
    send_literals(2);
    send_copy(3, 1);
  endtask

  task automatic test_literals_and_copies();
    send_start(24'd70);
    send_code(8'h01);
    send_code(8'h00);
    send_code(8'hFF);
    send_code(8'h00);
    send_code(8'h5A);
    send_copy(3, 1);
    send_copy(MAX_COPY_LEN, lzd_pkg::WINDOW_DEPTH);
    send_copy(20, 40);
    send_copy(MAX_COPY_LEN, 3);
  endtask

  task automatic test_restart_and_zero_length();
    send_start(24'd0);
    send_literals(1);
    send_start(24'd5);
    send_code(8'h85);
    send_start(24'd4);
    send_literals(4);
  endtask

  task automatic test_max_literal_run();
    send_start(24'd130);
    send_literals(MAX_LITERAL_RUN);
    send_copy(MAX_COPY_LEN, MAX_LITERAL_RUN);
  endtask

  task automatic test_long_window();
    int unsigned reach;
    send_start(24'hFFFFFF);
    send_literals(16);
    while (bytes_out < 24'd1100) begin
      reach = (bytes_out < lzd_pkg::WINDOW_DEPTH) ? bytes_out : lzd_pkg::WINDOW_DEPTH;
      send_copy(MAX_COPY_LEN, $urandom_range(1, reach));
    end
    send_copy(MAX_COPY_LEN, lzd_pkg::WINDOW_DEPTH);
    send_copy(lzd_pkg::COPY_MIN_LEN, lzd_pkg::WINDOW_DEPTH);
    send_literals(1);
  endtask

  task automatic test_random_streams(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned r;
    int unsigned tokens;
    int unsigned reach;
    logic [23:0] len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 5) len = '0;
      else if (r < 10) len = 24'($urandom);
      else len = 24'($urandom_range(1, 160));
      send_start(len);
      tokens = $urandom_range(4, 24);
      while (tokens != 0 && items_sent < stop_at) begin
        tokens--;
        r = $urandom_range(99);
        reach = (bytes_out < lzd_pkg::WINDOW_DEPTH) ? bytes_out : lzd_pkg::WINDOW_DEPTH;
        if (r < 40) begin
          send_literals(($urandom_range(19) == 0) ? $urandom_range(1, MAX_LITERAL_RUN)
                                                  : $urandom_range(1, 8));
        end else if (r < 85) begin
          if (reach != 0 && r < 80)
            send_copy($urandom_range(3, MAX_COPY_LEN),
                      ($urandom_range(1) != 0) ? $urandom_range(1, (reach < 4) ? reach : 4)
                                               : $urandom_range(1, reach));
          else
            send_copy($urandom_range(3, MAX_COPY_LEN),
                      $urandom_range(1, lzd_pkg::WINDOW_DEPTH));
        end else if (r < 93) begin
          send_code(8'($urandom));
        end else begin
          // broken token, then a fresh stream
          send_code(8'($urandom));
          tokens = 0;
        end
        if (bytes_out == stream_len && stream_len != 0 && $urandom_range(3) != 0) tokens = 0;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 15;
    stall_pct = 46;
    test_no_stream();
    test_literals_and_copies();
    test_restart_and_zero_length();
    test_random_streams(10);

    send_idle_pct = 46;
    stall_pct = 15;
    test_max_literal_run();
    test_long_window();
    test_random_streams(10);

    send_idle_pct = 0;
    stall_pct = 0;
    test_random_streams(10);

    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** lz_literal_copy_decompressor_unit: PASSED **");
    end else begin
      $display("** lz_literal_copy_decompressor_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("%0t: timeout", $time);
    $display("** lz_literal_copy_decompressor_unit: FAILED **");
    $finish;
  end

endmodule

[lz_literal_copy_decompressor_unit.f]
hdl/lzd_pkg.sv
hdl/lzd_ram.sv
hdl/lzd_ctrl.sv
hdl/lzd_datapath.sv
hdl/lz_literal_copy_decompressor_unit.sv
tb/sv/tb_top.sv
